>>> rtl/core/pds_pkg.sv
package pds_pkg;

  typedef struct packed {
    logic        command;
    logic [15:0] event_id;
    logic [1:0]  event_priority;
    logic [7:0]  event_duration;
    logic [1:0]  event_target;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  device;
    logic [15:0] done_id;
    logic [1:0]  done_priority;
    logic        last;
  } out_t;

  // result buffer control: push one item, or close the group (marks last)
  typedef struct packed {
    logic push;
    logic fin;
  } rb_ctl_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] KIND_DONE      = 2'd0;
  localparam logic [1:0] KIND_SVC_FULL  = 2'd1;
  localparam logic [1:0] KIND_PEND_FULL = 2'd2;

  localparam logic [1:0] DEV_CPU = 2'd0;
  localparam logic [1:0] DEV_IO  = 2'd1;
  localparam logic [1:0] DEV_NET = 2'd2;

  localparam logic [1:0] TGT_CPU = 2'd1;
  localparam logic [1:0] TGT_IO  = 2'd2;

endpackage

>>> rtl/core/pds_ram.sv
module pds_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/pds_result_buf.sv
module pds_result_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  pds_pkg::rb_ctl_t ctl,
  input  pds_pkg::out_t   item,
  output logic            rdy,
  output logic            out_valid,
  input  logic            out_stall,
  output pds_pkg::out_t   out_data
);
  import pds_pkg::*;

  // one item is held back until the next one (or the end) shows whether it is last
  logic hold_v_r, hold_v_nxt;
  out_t hold_r, hold_nxt;
  logic out_v_r, out_v_nxt;
  out_t out_r, out_nxt;
  logic out_free;

  assign out_free = !out_v_r || !out_stall;
  assign rdy      = !hold_v_r || out_free;

  always_comb begin
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    out_v_nxt  = out_v_r && out_stall;
    out_nxt    = out_r;
    if (ctl.push && rdy) begin
      if (hold_v_r) begin
        out_nxt      = hold_r;
        out_nxt.last = 1'b0;
        out_v_nxt    = 1'b1;
      end
      hold_nxt   = item;
      hold_v_nxt = 1'b1;
    end else if (ctl.fin && rdy && hold_v_r) begin
      out_nxt      = hold_r;
      out_nxt.last = 1'b1;
      out_v_nxt    = 1'b1;
      hold_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

>>> rtl/core/priority_dispatch_service_queues.sv
// Priority dispatch scheduler: one pending queue feeding cpu, io and network
// service queues. Lower priority number is better, equal priorities are FIFO.
// Input channel (in_valid/in_stall/in_data): command 0 loads an event into the
// pending queue; command 1 is a tick that dispatches the best pending event
// (or the new one if strictly better) to its device, then ages every
// non-empty device head by one and reports heads that reach zero.
// Output channel (out_valid/out_stall/out_data): zero to four items per input,
// in order drop, cpu, io, network; last marks the final item of an input.
// Each queue is kept as four FIFOs, one per priority class, living in a
// single-port-read RAM; pointers and counts sit in flops.
// A load passes through the enter and finish states; a tick reads the pending
// head (skipped on a bypass), writes the service queue, then walks the devices
// in turn, reading and updating each non-empty head, and finishes. A new input
// is taken only after the current one is done. Each result passes through the
// hold and output registers of the result buffer; the item held back for the
// last flag moves out when the next result or the end comes.
// Reset (synchronous, rst_n low) empties all queues; RAM contents need no
// clearing since only entries below a count are ever read.
// A stalled output holds its item; the sequencer waits and in_stall stays high
// until every result of the current input is buffered.
module priority_dispatch_service_queues #(
  parameter int PENDING_DEPTH = 32,
  parameter int SERVICE_DEPTH = 16,
  parameter int ID_BITS       = 16,
  parameter int DURATION_BITS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  pds_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output pds_pkg::out_t  out_data
);
  import pds_pkg::*;

  localparam int PW   = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PCW  = $clog2(PENDING_DEPTH + 1);
  localparam int SW   = (SERVICE_DEPTH > 1) ? $clog2(SERVICE_DEPTH) : 1;
  localparam int SCW  = $clog2(SERVICE_DEPTH + 1);
  localparam int PMW  = ID_BITS + DURATION_BITS + 2;  // id, duration, device
  localparam int SMW  = ID_BITS + DURATION_BITS;      // id, duration
  localparam int PAW  = PW + 2;                       // {class, slot}
  localparam int SAW  = SW + 4;                       // {device, class, slot}

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ENTER = 3'd1;
  localparam logic [2:0] S_PRD   = 3'd2;
  localparam logic [2:0] S_SVC   = 3'd3;
  localparam logic [2:0] S_DRD   = 3'd4;
  localparam logic [2:0] S_DUP   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_r, state_nxt;
  in_t        e_r, e_nxt;

  // event chosen for dispatch
  logic [ID_BITS-1:0]       best_id_r, best_id_nxt;
  logic [DURATION_BITS-1:0] best_dur_r, best_dur_nxt;
  logic [1:0]               best_dev_r, best_dev_nxt;
  logic [1:0]               best_prio_r, best_prio_nxt;

  // pending queue: one ring per priority class
  logic [PCW-1:0] pcnt_r [4];
  logic [PCW-1:0] pcnt_nxt [4];
  logic [PW-1:0]  phead_r [4];
  logic [PW-1:0]  phead_nxt [4];
  logic [PW-1:0]  ptail_r [4];
  logic [PW-1:0]  ptail_nxt [4];
  logic [PCW-1:0] ptot_r, ptot_nxt;

  // service queues: ring per device and class
  logic [SCW-1:0] scnt_r [3];
  logic [SCW-1:0] scnt_nxt [3];
  logic [SCW-1:0] sccnt_r [3][4];
  logic [SCW-1:0] sccnt_nxt [3][4];
  logic [SW-1:0]  shead_r [3][4];
  logic [SW-1:0]  shead_nxt [3][4];
  logic [SW-1:0]  stail_r [3][4];
  logic [SW-1:0]  stail_nxt [3][4];

  logic [1:0] dev_r, dev_nxt;
  logic [1:0] cls_r, cls_nxt;

  logic           pm_we, pm_re;
  logic [PAW-1:0] pm_waddr, pm_raddr;
  logic [PMW-1:0] pm_wdata, pm_rdata;
  logic           sm_we, sm_re;
  logic [SAW-1:0] sm_waddr, sm_raddr;
  logic [SMW-1:0] sm_wdata, sm_rdata;

  rb_ctl_t rb_ctl;
  out_t    rb_item;
  logic    rb_rdy;

  // decoded arriving event, chosen event and service read data
  logic [31:0]              e_id32, best_id32, s_id32;
  logic [15:0]              e_dur16;
  logic [ID_BITS-1:0]       e_idk, s_id;
  logic [DURATION_BITS-1:0] e_durk, s_dur, s_dur_dec;
  logic [1:0]               e_dev, e_prio;
  logic [1:0]               pbest, sbest;

  assign e_prio = e_r.event_priority;
  assign e_dev  = (e_r.event_target == TGT_CPU) ? DEV_CPU :
                  (e_r.event_target == TGT_IO)  ? DEV_IO  : DEV_NET;
  assign {s_id, s_dur} = sm_rdata;
  assign s_dur_dec = (s_dur == '0) ? '0 : s_dur - 1'b1;

  always_comb begin
    e_id32  = {16'b0, e_r.event_id};
    e_idk   = e_id32[ID_BITS-1:0];
    e_dur16 = {8'b0, e_r.event_duration};
    e_durk  = e_dur16[DURATION_BITS-1:0];
    e_id32  = '0;
    e_id32[ID_BITS-1:0] = e_idk;
    best_id32 = '0;
    best_id32[ID_BITS-1:0] = best_id_r;
    s_id32 = '0;
    s_id32[ID_BITS-1:0] = s_id;
  end

  // best non-empty class, pending and current device
  always_comb begin
    pbest = 2'd3;
    sbest = 2'd3;
    for (int c = 3; c >= 0; c--) begin
      if (pcnt_r[c] != '0) pbest = 2'(c);
      if (sccnt_r[dev_r][c] != '0) sbest = 2'(c);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    e_nxt         = e_r;
    best_id_nxt   = best_id_r;
    best_dur_nxt  = best_dur_r;
    best_dev_nxt  = best_dev_r;
    best_prio_nxt = best_prio_r;
    pcnt_nxt      = pcnt_r;
    phead_nxt     = phead_r;
    ptail_nxt     = ptail_r;
    ptot_nxt      = ptot_r;
    scnt_nxt      = scnt_r;
    sccnt_nxt     = sccnt_r;
    shead_nxt     = shead_r;
    stail_nxt     = stail_r;
    dev_nxt       = dev_r;
    cls_nxt       = cls_r;
    pm_we = 1'b0; pm_waddr = '0; pm_wdata = '0;
    pm_re = 1'b0; pm_raddr = '0;
    sm_we = 1'b0; sm_waddr = '0; sm_wdata = '0;
    sm_re = 1'b0; sm_raddr = '0;
    rb_ctl  = '0;
    rb_item = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          e_nxt     = in_data;
          state_nxt = S_ENTER;
        end
      end
      S_ENTER: begin
        if (e_r.command == CMD_LOAD) begin
          if (ptot_r >= PCW'(PENDING_DEPTH)) begin
            rb_item.result_kind   = KIND_PEND_FULL;
            rb_item.device        = e_dev;
            rb_item.done_id       = e_id32[15:0];
            rb_item.done_priority = e_prio;
            rb_ctl.push           = 1'b1;
            if (rb_rdy) state_nxt = S_FIN;
          end else begin
            pm_we             = 1'b1;
            pm_waddr          = {e_prio, ptail_r[e_prio]};
            pm_wdata          = {e_idk, e_durk, e_dev};
            ptail_nxt[e_prio] = (ptail_r[e_prio] == PW'(PENDING_DEPTH - 1)) ? '0 :
                                ptail_r[e_prio] + 1'b1;
            pcnt_nxt[e_prio]  = pcnt_r[e_prio] + 1'b1;
            ptot_nxt          = ptot_r + 1'b1;
            state_nxt         = S_FIN;
          end
        end else if (ptot_r == '0 || e_prio < pbest) begin
          // new event bypasses the pending queue
          best_id_nxt   = e_idk;
          best_dur_nxt  = e_durk;
          best_dev_nxt  = e_dev;
          best_prio_nxt = e_prio;
          state_nxt     = S_SVC;
        end else begin
          pm_re            = 1'b1;
          pm_raddr         = {pbest, phead_r[pbest]};
          phead_nxt[pbest] = (phead_r[pbest] == PW'(PENDING_DEPTH - 1)) ? '0 :
                             phead_r[pbest] + 1'b1;
          pcnt_nxt[pbest]  = pcnt_r[pbest] - 1'b1;
          ptot_nxt         = ptot_r - 1'b1;
          best_prio_nxt    = pbest;
          state_nxt        = S_PRD;
        end
      end
      S_PRD: begin
        {best_id_nxt, best_dur_nxt, best_dev_nxt} = pm_rdata;
        pm_we             = 1'b1;
        pm_waddr          = {e_prio, ptail_r[e_prio]};
        pm_wdata          = {e_idk, e_durk, e_dev};
        ptail_nxt[e_prio] = (ptail_r[e_prio] == PW'(PENDING_DEPTH - 1)) ? '0 :
                            ptail_r[e_prio] + 1'b1;
        pcnt_nxt[e_prio]  = pcnt_r[e_prio] + 1'b1;
        ptot_nxt          = ptot_r + 1'b1;
        state_nxt         = S_SVC;
      end
      S_SVC: begin
        if (scnt_r[best_dev_r] >= SCW'(SERVICE_DEPTH)) begin
          rb_item.result_kind   = KIND_SVC_FULL;
          rb_item.device        = best_dev_r;
          rb_item.done_id       = best_id32[15:0];
          rb_item.done_priority = best_prio_r;
          rb_ctl.push           = 1'b1;
          if (rb_rdy) begin
            dev_nxt   = DEV_CPU;
            state_nxt = S_DRD;
          end
        end else begin
          sm_we    = 1'b1;
          sm_waddr = {best_dev_r, best_prio_r, stail_r[best_dev_r][best_prio_r]};
          sm_wdata = {best_id_r, best_dur_r};
          stail_nxt[best_dev_r][best_prio_r] =
            (stail_r[best_dev_r][best_prio_r] == SW'(SERVICE_DEPTH - 1)) ? '0 :
            stail_r[best_dev_r][best_prio_r] + 1'b1;
          sccnt_nxt[best_dev_r][best_prio_r] = sccnt_r[best_dev_r][best_prio_r] + 1'b1;
          scnt_nxt[best_dev_r] = scnt_r[best_dev_r] + 1'b1;
          dev_nxt   = DEV_CPU;
          state_nxt = S_DRD;
        end
      end
      S_DRD: begin
        if (scnt_r[dev_r] == '0) begin
          if (dev_r == DEV_NET) state_nxt = S_FIN;
          else dev_nxt = dev_r + 1'b1;
        end else begin
          sm_re     = 1'b1;
          sm_raddr  = {dev_r, sbest, shead_r[dev_r][sbest]};
          cls_nxt   = sbest;
          state_nxt = S_DUP;
        end
      end
      S_DUP: begin
        if (s_dur_dec == '0) begin
          // head finished: report and pop
          rb_item.result_kind   = KIND_DONE;
          rb_item.device        = dev_r;
          rb_item.done_id       = s_id32[15:0];
          rb_item.done_priority = cls_r;
          rb_ctl.push           = 1'b1;
          if (rb_rdy) begin
            shead_nxt[dev_r][cls_r] =
              (shead_r[dev_r][cls_r] == SW'(SERVICE_DEPTH - 1)) ? '0 :
              shead_r[dev_r][cls_r] + 1'b1;
            sccnt_nxt[dev_r][cls_r] = sccnt_r[dev_r][cls_r] - 1'b1;
            scnt_nxt[dev_r] = scnt_r[dev_r] - 1'b1;
            if (dev_r == DEV_NET) state_nxt = S_FIN;
            else begin
              dev_nxt   = dev_r + 1'b1;
              state_nxt = S_DRD;
            end
          end
        end else begin
          sm_we    = 1'b1;
          sm_waddr = {dev_r, cls_r, shead_r[dev_r][cls_r]};
          sm_wdata = {s_id, s_dur_dec};
          if (dev_r == DEV_NET) state_nxt = S_FIN;
          else begin
            dev_nxt   = dev_r + 1'b1;
            state_nxt = S_DRD;
          end
        end
      end
      S_FIN: begin
        rb_ctl.fin = 1'b1;
        if (rb_rdy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ptot_r  <= '0;
      for (int c = 0; c < 4; c++) begin
        pcnt_r[c]  <= '0;
        phead_r[c] <= '0;
        ptail_r[c] <= '0;
      end
      for (int d = 0; d < 3; d++) begin
        scnt_r[d] <= '0;
        for (int c = 0; c < 4; c++) begin
          sccnt_r[d][c] <= '0;
          shead_r[d][c] <= '0;
          stail_r[d][c] <= '0;
        end
      end
      dev_r <= DEV_CPU;
    end else begin
      state_r <= state_nxt;
      ptot_r  <= ptot_nxt;
      pcnt_r  <= pcnt_nxt;
      phead_r <= phead_nxt;
      ptail_r <= ptail_nxt;
      scnt_r  <= scnt_nxt;
      sccnt_r <= sccnt_nxt;
      shead_r <= shead_nxt;
      stail_r <= stail_nxt;
      dev_r   <= dev_nxt;
    end
    e_r         <= e_nxt;
    best_id_r   <= best_id_nxt;
    best_dur_r  <= best_dur_nxt;
    best_dev_r  <= best_dev_nxt;
    best_prio_r <= best_prio_nxt;
    cls_r       <= cls_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

  pds_ram #(.W(PMW), .DEPTH(4 << PW), .AW(PAW)) u_pend_ram (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .re    (pm_re),
    .raddr (pm_raddr),
    .rdata (pm_rdata)
  );

  pds_ram #(.W(SMW), .DEPTH(16 << SW), .AW(SAW)) u_svc_ram (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .re    (sm_re),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  pds_result_buf u_rbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rb_ctl),
    .item      (rb_item),
    .rdy       (rb_rdy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> verif/tb_priority_dispatch_service_queues.sv
module tb_priority_dispatch_service_queues;
  import pds_pkg::*;

  // Predicted scheduler: pending queue plus three device queues. An entry holds
  // id, priority, remaining duration and device. Equal priorities stay FIFO.
  typedef struct {
    logic [15:0] id;
    logic [1:0]  prio;
    logic [7:0]  dur;
    logic [1:0]  dev;
  } evt_t;

  localparam int PEND_DEPTH = 32;
  localparam int SVC_DEPTH  = 16;

  class sched_scoreboard;
    evt_t   pend_q[$];
    evt_t   svc_q[3][$];
    out_t   want_q[$];
    int     errors;
    int     results_seen;
    int     drops_seen;
    int     finishes_seen;

    function void sorted_put(ref evt_t q[$], input evt_t e);
      int pos;
      pos = 0;
      while (pos < q.size() && q[pos].prio <= e.prio) pos++;
      q.insert(pos, e);
    endfunction

    function void push_result(logic [1:0] kind, logic [1:0] dev, evt_t e);
      out_t r;
      r.result_kind   = kind;
      r.device        = dev;
      r.done_id       = e.id;
      r.done_priority = e.prio;
      r.last          = 1'b0;
      want_q.push_back(r);
    endfunction

    // Work out every result that one accepted input item causes.
    function void note_input(in_t it);
      evt_t e;
      evt_t best;
      int   first;
      first = want_q.size();
      e.id   = it.event_id;
      e.prio = it.event_priority;
      e.dur  = it.event_duration;
      e.dev  = (it.event_target == TGT_CPU) ? DEV_CPU :
               (it.event_target == TGT_IO) ? DEV_IO : DEV_NET;
      if (it.command == CMD_LOAD) begin
        if (pend_q.size() >= PEND_DEPTH) push_result(KIND_PEND_FULL, e.dev, e);
        else sorted_put(pend_q, e);
      end else begin
        // new arrival bypasses only when strictly better than the head
        if (pend_q.size() == 0 || e.prio < pend_q[0].prio) begin
          best = e;
        end else begin
          best = pend_q.pop_front();
          sorted_put(pend_q, e);
        end
        if (svc_q[best.dev].size() >= SVC_DEPTH)
          push_result(KIND_SVC_FULL, best.dev, best);
        else
          sorted_put(svc_q[best.dev], best);
        for (int d = 0; d < 3; d++) begin
          if (svc_q[d].size() != 0) begin
            if (svc_q[d][0].dur > 0) svc_q[d][0].dur = svc_q[d][0].dur - 8'd1;
            if (svc_q[d][0].dur == 0) push_result(KIND_DONE, d[1:0], svc_q[d].pop_front());
          end
        end
      end
      if (want_q.size() > first) want_q[want_q.size() - 1].last = 1'b1;
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      results_seen++;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected item %p", $time, got);
        errors++;
        return;
      end
      exp_r = want_q.pop_front();
      if (exp_r.result_kind == KIND_DONE) finishes_seen++;
      else drops_seen++;
      if (got !== exp_r) begin
        $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
        errors++;
      end
    endfunction
  endclass

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  in_t   in_data;
  logic  out_valid;
  logic  out_stall;
  out_t  out_data;

  sched_scoreboard sb;
  bit    calm;        // last stretch: no idling on either side
  bit    hold_out;    // long receiver hold-off for back-pressure
  int    n_sent;

  priority_dispatch_service_queues dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Limit: a safety bound for a worst correct run of ~500 items with gaps and stalls.
  initial begin
    #20000000;
    $display("TB_TIMEOUT");
    $display("TB_ERROR");
    $finish;
  end

  // Result side: random stall bursts, plus the hold-off window.
  initial begin
    int burst;
    out_stall = 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_out) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Sample at the edge: accepted when valid high and stall low.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Offer one item and hold it until accepted; an idle gap may come before it.
  task automatic send_item(in_t it);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    n_sent++;
  endtask

  function automatic in_t make_item(logic cmd, logic [1:0] prio, logic [1:0] tgt,
                                    logic [7:0] dur);
    in_t it;
    it.command        = cmd;
    it.event_id       = 16'($urandom);
    it.event_priority = prio;
    it.event_duration = dur;
    it.event_target   = tgt;
    return it;
  endfunction

  // Mostly legal fields, with occasional priority 0, target 0 and duration 0.
  function automatic in_t rand_item(int tick_pct);
    logic [7:0] dur;
    dur = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                                        8'($urandom_range(0, 6));
    return make_item($urandom_range(0, 99) < tick_pct,
                     ($urandom_range(0, 19) == 0) ? 2'd0 : 2'($urandom_range(1, 3)),
                     ($urandom_range(0, 19) == 0) ? 2'd0 : 2'($urandom_range(1, 3)),
                     dur);
  endfunction

  initial begin
    int guard;
    sb       = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    calm     = 1'b0;
    hold_out = 1'b0;
    n_sent   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, both commands, bypass, FIFO ties, odd codes.
    send_item(make_item(CMD_TICK, 2'd3, TGT_CPU, 8'd1));      // tick on empty pending
    send_item(make_item(CMD_LOAD, 2'd3, TGT_IO, 8'd255));
    send_item(make_item(CMD_LOAD, 2'd3, TGT_IO, 8'd2));       // equal prio, FIFO
    send_item(make_item(CMD_TICK, 2'd1, DEV_NET + 2'd1, 8'd3)); // strict bypass
    send_item(make_item(CMD_TICK, 2'd3, TGT_IO, 8'd0));       // ties head: head goes
    send_item(make_item(CMD_TICK, 2'd0, 2'd0, 8'd0));         // prio 0, target 0, dur 0
    send_item(make_item(CMD_TICK, 2'd2, TGT_IO, 8'd1));
    send_item(make_item(CMD_TICK, 2'd1, TGT_IO, 8'd1));       // preempts io head
    begin
      in_t x;
      x = make_item(CMD_LOAD, 2'd1, TGT_CPU, 8'd0);
      x.event_id = 16'hFFFF;
      send_item(x);
      x = make_item(CMD_TICK, 2'd2, TGT_CPU, 8'd4);
      x.event_id = 16'h0000;
      send_item(x);
    end

    // Fill pending to overflow, and push cpu queue past full while the
    // receiver holds off so the block backs up into its input.
    hold_out <= 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_out <= 1'b0;
      end
    join_none
    for (int i = 0; i < 36; i++) send_item(make_item(CMD_LOAD, 2'($urandom_range(1, 3)),
                                                    TGT_CPU, 8'd200));
    for (int i = 0; i < 20; i++) send_item(make_item(CMD_TICK, 2'($urandom_range(1, 3)),
                                                    TGT_CPU, 8'd200));
    // Age the long cpu jobs with mostly short random items so ticks keep coming.
    for (int i = 0; i < 60; i++) send_item(rand_item(80));

    // Random: phases of heavy loading and heavy ticking.
    for (int i = 0; i < 340; i++) begin
      if (i == 300) calm = 1'b1;
      send_item(rand_item(((i / 50) % 2 == 0) ? 45 : 85));
    end
    in_valid <= 1'b0;

    guard = 0;
    while (sb.want_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (sb.want_q.size() != 0) begin
      $display("%0t: %0d expected items never came", $time, sb.want_q.size());
      sb.errors++;
    end
    $display("Sent %0d items; checked %0d results (%0d finishes, %0d drops).",
             n_sent, sb.results_seen, sb.finishes_seen, sb.drops_seen);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
